// ===== sv/scm_pkg.sv =====
// Shared types and constants for the supercap charge mode controller.
package scm_pkg;

  typedef enum logic [1:0] {
    ST_BOOTUP = 2'd0,
    ST_OFF    = 2'd1,
    ST_SLOW   = 2'd2,
    ST_FAST   = 2'd3
  } mode_t;

  localparam logic [11:0] OVER_MV      = 12'd3500;
  localparam logic [11:0] MV_PER_COUNT = 12'd14;
  localparam logic [11:0] OFF_UP_MV    = 12'd2700;
  localparam logic [11:0] LOW_OFF_MV   = 12'd2500;
  localparam logic [11:0] SLOW_UP_MV   = 12'd2950;
  localparam logic [11:0] FAST_DOWN_MV = 12'd2700;

endpackage

// ===== sv/supercap_charge_mode_controller.sv =====
// Supercap charge mode controller: four-state charge mode machine with one result register.
// The result beat for an accepted input beat is registered and on the output in the next cycle.
// Throughput: one beat per cycle; the result register frees in the cycle it is taken,
// so in_ready stays high while the output side keeps up.
// Reset (rst, synchronous, active high): state to bootup, counters cleared,
// self-test disabled, output empty.
module supercap_charge_mode_controller #(
  parameter int TICKS_SECOND = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] vcc_mv,
  input  logic [31:0] elapsed_ticks,
  input  logic [7:0]  cap_counts,
  input  logic        force_stop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  charge_state,
  output logic        is_charging,
  output logic [7:0]  voltage_delta
);
  import scm_pkg::*;

  localparam logic [31:0] BOOT_TICKS = 32'(2 * TICKS_SECOND);
  localparam logic [7:0]  SLOW_THR   = 8'(TICKS_SECOND / 2);
  localparam logic [7:0]  FAST_THR   = 8'(4 * TICKS_SECOND);

  mode_t       mode, mode_next;
  logic [7:0]  stable_count, stable_count_next;
  logic [7:0]  latched_counts, latched_counts_next;
  logic        self_test_enable;

  logic        accept;
  logic        vcc_low, over_range, over_hit, drop, chain_latch;
  logic [11:0] cap_x14, vcc_over;
  logic        charging_next;
  logic [7:0]  delta_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Overcharge: counts <= floor((vcc - 3500) / 14) is the same as counts * 14 <= vcc - 3500.
  assign cap_x14     = 12'(cap_counts) * MV_PER_COUNT;
  assign vcc_over    = vcc_mv - OVER_MV;
  assign vcc_low     = vcc_mv < LOW_OFF_MV;
  assign over_range  = vcc_mv > OVER_MV;
  assign over_hit    = over_range && (cap_x14 <= vcc_over);
  assign drop        = vcc_low || force_stop || over_hit;
  // The drop chain reads the ADC only once low supply and stop have both passed and the supply is over OVER_MV.
  assign chain_latch = !vcc_low && !force_stop && over_range;

  always_comb begin
    mode_next           = mode;
    stable_count_next   = stable_count;
    latched_counts_next = latched_counts;
    case (mode)
      ST_BOOTUP: begin
        if (elapsed_ticks > BOOT_TICKS) begin
          mode_next = ST_OFF;
        end else if (self_test_enable) begin
          mode_next = ST_FAST;
        end
      end
      ST_OFF: begin
        if (vcc_mv > OFF_UP_MV) begin
          if (stable_count > SLOW_THR) begin
            mode_next         = ST_SLOW;
            stable_count_next = '0;
          end else begin
            stable_count_next = stable_count + 8'd1;
          end
        end else begin
          stable_count_next = '0;
        end
      end
      ST_SLOW: begin
        if (chain_latch) latched_counts_next = cap_counts;
        if (drop) begin
          mode_next = ST_OFF;
        end else if (vcc_mv > SLOW_UP_MV) begin
          if (stable_count > FAST_THR) begin
            mode_next         = ST_FAST;
            stable_count_next = '0;
          end else begin
            stable_count_next = stable_count + 8'd1;
          end
        end else begin
          stable_count_next = '0;
        end
      end
      ST_FAST: begin
        if (self_test_enable) begin
          latched_counts_next = cap_counts;
          if (over_hit || force_stop) mode_next = ST_OFF;
        end else begin
          if (chain_latch) latched_counts_next = cap_counts;
          if (drop) begin
            mode_next = ST_OFF;
          end else if (vcc_mv < FAST_DOWN_MV) begin
            mode_next = ST_SLOW;
          end
        end
      end
      default: begin
        mode_next = ST_BOOTUP;
      end
    endcase
  end

  always_comb begin
    charging_next = (mode_next == ST_SLOW) || (mode_next == ST_FAST);
    delta_next    = charging_next ? latched_counts_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= ST_BOOTUP;
      stable_count     <= '0;
      latched_counts   <= '0;
      self_test_enable <= 1'b0;
    end else begin
      if (cfg_we) self_test_enable <= cfg_wdata;
      if (accept) begin
        mode           <= mode_next;
        stable_count   <= stable_count_next;
        latched_counts <= latched_counts_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result beat alongside the state update.
  always_ff @(posedge clk) begin
    if (accept) begin
      charge_state  <= mode_next;
      is_charging   <= charging_next;
      voltage_delta <= delta_next;
    end
  end

endmodule

// ===== sv/scm_checker.sv =====
// Port-level checks for the supercap charge mode controller, with their bind.
module scm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  charge_state,
  input logic        is_charging,
  input logic [7:0]  voltage_delta
);
  import scm_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(charge_state) &&
      $stable(is_charging) && $stable(voltage_delta))
    else $error("result beat changed while stalled");

  // An accepted input beat yields a result beat in the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // The charging flag agrees with the reported state.
  a_charging: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_charging == (charge_state == ST_SLOW || charge_state == ST_FAST))
    else $error("is_charging disagrees with charge_state");

  // No ADC count is reported while not charging.
  a_delta_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_charging |-> voltage_delta == 8'd0)
    else $error("voltage_delta nonzero while not charging");

  // The input side stays open whenever the result register can drain.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with a free result register");

endmodule

bind supercap_charge_mode_controller scm_checker u_scm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .charge_state  (charge_state),
  .is_charging   (is_charging),
  .voltage_delta (voltage_delta)
);

// ===== tb/sv/tb.sv =====
// Testbench for the supercap charge mode controller: directed and random tick streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scm_pkg::*;

  localparam int TICKS = 32;
  localparam int QUIET_LIMIT = 500;

  // Own copies of the voltage thresholds, kept apart from the package.
  localparam logic [11:0] OVERCHARGE_MV = 12'd3500;
  localparam logic [11:0] MV_STEP       = 12'd14;
  localparam logic [11:0] OFF_RISE_MV   = 12'd2700;
  localparam logic [11:0] LOW_DROP_MV   = 12'd2500;
  localparam logic [11:0] SLOW_RISE_MV  = 12'd2950;
  localparam logic [11:0] FAST_FALL_MV  = 12'd2700;

  typedef struct {
    mode_t      state;
    logic       charging;
    logic [7:0] delta;
  } mode_report_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] vcc_mv;
  logic [31:0] elapsed_ticks;
  logic [7:0]  cap_counts;
  logic        force_stop;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  charge_state;
  logic        is_charging;
  logic [7:0]  voltage_delta;

  // Predicted block state.
  mode_t      pred_mode;
  logic [7:0] pred_stable;
  logic [7:0] pred_latch;
  logic       pred_self_test;

  mode_report_t mode_reports_q[$];
  logic idle_on = 1'b1;
  int   ticks_sent = 0;
  int   reports_seen = 0;
  int   mismatches = 0;
  int   self_test_writes = 0;
  int   mode_hits[4] = '{0, 0, 0, 0};
  int   ready_stall = 0;
  int   quiet_cycles = 0;

  supercap_charge_mode_controller #(.TICKS_SECOND(TICKS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vcc_mv       (vcc_mv),
    .elapsed_ticks(elapsed_ticks),
    .cap_counts   (cap_counts),
    .force_stop   (force_stop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .charge_state (charge_state),
    .is_charging  (is_charging),
    .voltage_delta(voltage_delta)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Overcharge test; latches the ADC count only when the supply is high enough.
  function automatic logic cap_full(logic [11:0] vcc, logic [7:0] counts);
    logic [11:0] margin;
    if (vcc > OVERCHARGE_MV) begin
      margin = (vcc - OVERCHARGE_MV) / MV_STEP;
      pred_latch = counts;
      return {4'd0, counts} <= margin;
    end
    return 1'b0;
  endfunction

  function automatic logic must_stop(logic [11:0] vcc, logic stop, logic [7:0] counts);
    if (vcc < LOW_DROP_MV) return 1'b1;
    if (stop) return 1'b1;
    return cap_full(vcc, counts);
  endfunction

  function automatic mode_report_t advance_mode(logic [11:0] vcc, logic [31:0] ticks,
                                                logic [7:0] counts, logic stop);
    mode_t        nxt;
    mode_report_t r;
    nxt = pred_mode;
    case (pred_mode)
      ST_BOOTUP: begin
        if (ticks > 32'(2 * TICKS)) nxt = ST_OFF;
        else if (pred_self_test) nxt = ST_FAST;
      end
      ST_OFF: begin
        if (vcc > OFF_RISE_MV) begin
          if (pred_stable > 8'(TICKS / 2)) begin
            nxt = ST_SLOW;
            pred_stable = 8'd0;
          end else begin
            pred_stable = pred_stable + 8'd1;
          end
        end else begin
          pred_stable = 8'd0;
        end
      end
      ST_SLOW: begin
        if (must_stop(vcc, stop, counts)) begin
          nxt = ST_OFF;
        end else if (vcc > SLOW_RISE_MV) begin
          if (pred_stable > 8'(4 * TICKS)) begin
            nxt = ST_FAST;
            pred_stable = 8'd0;
          end else begin
            pred_stable = pred_stable + 8'd1;
          end
        end else begin
          pred_stable = 8'd0;
        end
      end
      default: begin
        if (pred_self_test) begin
          pred_latch = counts;
          if (cap_full(vcc, counts) || stop) nxt = ST_OFF;
        end else begin
          if (must_stop(vcc, stop, counts)) nxt = ST_OFF;
          else if (vcc < FAST_FALL_MV) nxt = ST_SLOW;
        end
      end
    endcase
    pred_mode = nxt;
    r.state = nxt;
    r.charging = (nxt == ST_SLOW) || (nxt == ST_FAST);
    r.delta = r.charging ? pred_latch : 8'd0;
    return r;
  endfunction

  task automatic send_tick(input logic [11:0] vcc, input logic [31:0] ticks,
                           input logic [7:0] counts, input logic stop);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    vcc_mv        <= vcc;
    elapsed_ticks <= ticks;
    cap_counts    <= counts;
    force_stop    <= stop;
    do @(posedge clk); while (!in_ready);
    mode_reports_q.push_back(advance_mode(vcc, ticks, counts, stop));
    ticks_sent++;
  endtask

  // Hold the sender until every predicted report has come back.
  task automatic wait_reports_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mode_reports_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_self_test(input logic enable);
    wait_reports_done();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= enable;
    @(posedge clk);
    pred_self_test = enable;
    self_test_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly steady high supply with safe ADC counts; disturbances are rare in slow
  // so the long upshift count can complete.
  task automatic send_random_tick();
    logic [11:0] vcc;
    logic [7:0]  counts;
    logic        stop;
    int unsigned rate;
    case (pred_mode)
      ST_SLOW: rate = 4;
      ST_FAST: rate = 60;
      default: rate = 30;
    endcase
    stop = 1'b0;
    vcc = 12'($urandom_range(2951, 4095));
    if (vcc > OVERCHARGE_MV)
      counts = 8'($urandom_range((vcc - OVERCHARGE_MV) / MV_STEP + 1, 255));
    else
      counts = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 999) < rate) begin
      case ($urandom_range(0, 4))
        0: stop = 1'b1;
        1: vcc = 12'($urandom_range(0, 2499));
        2: vcc = 12'($urandom_range(2500, 2950));
        3: begin
          vcc = 12'($urandom_range(3501, 4095));
          counts = 8'($urandom_range(0, (vcc - OVERCHARGE_MV) / MV_STEP));
        end
        default: begin
          vcc = 12'($urandom);
          counts = 8'($urandom);
          stop = 1'($urandom);
        end
      endcase
    end
    send_tick(vcc, $urandom, counts, stop);
  endtask

  task automatic test_bootup_hold();
    send_tick(12'd0, 32'd0, 8'd0, 1'b0);
    send_tick(12'd4095, 32'(2 * TICKS), 8'd255, 1'b1);
  endtask

  task automatic test_self_test_fast();
    set_self_test(1'b1);
    send_tick(12'd3000, 32'(2 * TICKS), 8'd200, 1'b0);
    send_tick(12'd4095, 32'hFFFF_FFFF, 8'd255, 1'b0);
    send_tick(12'd3500, 32'd100, 8'd0, 1'b0);
    send_tick(12'd1000, 32'd101, 8'd17, 1'b0);
  endtask

  task automatic test_fast_downshift();
    set_self_test(1'b0);
    send_tick(12'd2700, 32'd200, 8'd9, 1'b0);
    send_tick(12'd2699, 32'd201, 8'd9, 1'b0);
  endtask

  task automatic test_slow_hold_and_stop();
    send_tick(12'd4095, 32'd300, 8'd43, 1'b0);
    send_tick(12'd2500, 32'd301, 8'd0, 1'b0);
    send_tick(12'd3000, 32'd302, 8'd7, 1'b1);
  endtask

  // The dropped stop tick must not have latched its count: slow reports the old one.
  task automatic test_off_climb();
    send_tick(12'd2700, 32'd400, 8'd0, 1'b0);
    repeat (TICKS / 2 + 2) send_tick(12'd2701, $urandom, 8'd0, 1'b0);
  endtask

  task automatic test_slow_overcharge();
    send_tick(12'd4095, 32'd500, 8'd42, 1'b0);
  endtask

  task automatic test_random_ticks(input int n, input logic enable, input logic with_idle);
    set_self_test(enable);
    idle_on = with_idle;
    repeat (n) send_random_tick();
  endtask

  always @(negedge clk) begin
    if (idle_on && ready_stall == 0 && $urandom_range(0, 5) == 0)
      ready_stall = $urandom_range(1, 3);
    if (ready_stall > 0) begin
      out_ready <= 1'b0;
      ready_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mode_report_t exp;
    if (!rst && out_valid && out_ready) begin
      reports_seen++;
      if (mode_reports_q.size() == 0) begin
        $display("%0t: unexpected result beat, state %0d", $time, charge_state);
        mismatches++;
      end else begin
        exp = mode_reports_q.pop_front();
        mode_hits[exp.state]++;
        if (charge_state !== exp.state) begin
          $display("%0t: charge_state expected %0d got %0d", $time, exp.state, charge_state);
          mismatches++;
        end
        if (is_charging !== exp.charging) begin
          $display("%0t: is_charging expected %0d got %0d", $time, exp.charging, is_charging);
          mismatches++;
        end
        if (voltage_delta !== exp.delta) begin
          $display("%0t: voltage_delta expected %0d got %0d", $time, exp.delta,
                   voltage_delta);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    vcc_mv = '0;
    elapsed_ticks = '0;
    cap_counts = '0;
    force_stop = 1'b0;
    out_ready = 1'b0;
    pred_mode = ST_BOOTUP;
    pred_stable = 8'd0;
    pred_latch = 8'd0;
    pred_self_test = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_bootup_hold();
    test_self_test_fast();
    test_fast_downshift();
    test_slow_hold_and_stop();
    test_off_climb();
    test_slow_overcharge();
    test_random_ticks(175, 1'b1, 1'b1);
    test_random_ticks(175, 1'b0, 1'b1);
    test_random_ticks(175, 1'b1, 1'b1);
    test_random_ticks(175, 1'b0, 1'b0);

    wait_reports_done();
    repeat (3) @(posedge clk);
    $display("Sent %0d ticks, checked %0d results, %0d self-test writes",
             ticks_sent, reports_seen, self_test_writes);
    $display("Results per mode: bootup %0d, off %0d, slow %0d, fast %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
